/* sv/ks_pkg.sv */
// ----------------------------------------------------------------------------
// ks_pkg
// Shared types and constants for the key sorter.
// ----------------------------------------------------------------------------
package ks_pkg;

  localparam int unsigned KEY_W = 32;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ks_state_t;

endpackage

/* sv/ks_if.sv */
// ----------------------------------------------------------------------------
// ks_in_if / ks_out_if
// Valid/ready channels for incoming keys and sorted results.
// ----------------------------------------------------------------------------
interface ks_in_if;
  import ks_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

interface ks_out_if;
  import ks_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_key;
  logic             final_res;

  modport source (output valid, output sorted_key, output final_res, input ready);
  modport sink   (input valid, input sorted_key, input final_res, output ready);
endinterface

/* sv/ks_cell.sv */
// ----------------------------------------------------------------------------
// ks_cell
// One slot of the insertion chain: holds a key, compares it against the
// incoming key, and takes its left or right neighbor's key as commanded.
// ----------------------------------------------------------------------------
module ks_cell #(
  parameter int unsigned KW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ks_pkg::cell_cmd_t cmd,
  input  logic [KW-1:0]     new_key,
  input  logic              left_gt,
  input  logic              left_vld,
  input  logic [KW-1:0]     left_key,
  input  logic              right_vld,
  input  logic [KW-1:0]     right_key,
  output logic              gt,
  output logic              vld,
  output logic [KW-1:0]     key
);
  import ks_pkg::*;

  // An empty slot sorts above every key.
  assign gt = !vld || (key > new_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      case (cmd)
        CELL_INSERT: begin
          if (gt) begin
            vld <= left_gt ? left_vld : 1'b1;
          end
        end
        CELL_SHIFT: vld <= right_vld;
        default:    vld <= vld;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_INSERT: begin
        if (gt) begin
          key <= left_gt ? left_key : new_key;
        end
      end
      CELL_SHIFT: key <= right_key;
      default:    key <= key;
    endcase
  end

endmodule

/* sv/key_sorter.sv */
// ----------------------------------------------------------------------------
// key_sorter
// Insertion-chain sorter: loads a set of keys, returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   keys   : one key per transfer; last marks the end of the set. A set also
//            ends on the transfer that fills all DEPTH slots.
//   sorted : the set's keys in ascending unsigned order, one per transfer,
//            final_res on the largest.
// Timing:
//   Loading takes one key per cycle; each key drops straight into its sorted
//   place in the cell chain, so no sort pass follows the load.
//   The ending transfer puts the control in its drain state; each shift then
//   loads the head key into the output register and moves the chain one key
//   toward it, one key per cycle unless stalled; n keys take n loads, n shifts.
//   keys.ready is low while a set drains; it rises as the final result enters
//   the output register, so a new set can load while that result waits.
// Reset: empties the chain and the output register; no clearing pass.
// Stall: when sorted.ready is low while a result waits, the output register
//   holds and the chain stops shifting; nothing is lost.
// ----------------------------------------------------------------------------
module key_sorter #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  ks_in_if.sink     keys,
  ks_out_if.source  sorted
);
  import ks_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ks_state_t          state, state_next;
  logic [CW-1:0]      cnt;
  cell_cmd_t          cmd;
  logic               load_xfer;
  logic               shift;
  logic [KW-1:0]      new_key;

  logic [DEPTH-1:0]   cvld;
  logic [DEPTH-1:0]   cgt;
  logic [KW-1:0]      ckey [DEPTH];

  logic               ovalid;
  logic [KEY_W-1:0]   okey;
  logic               ofinal;

  assign new_key     = keys.key[KW-1:0];
  assign keys.ready  = (state == ST_LOAD);
  assign load_xfer   = keys.valid && keys.ready;
  assign shift       = (state == ST_DRAIN) && (!ovalid || sorted.ready);

  always_comb begin
    state_next = state;
    cmd        = CELL_HOLD;
    case (state)
      ST_LOAD: begin
        if (load_xfer) begin
          cmd = CELL_INSERT;
          if (keys.last || (cnt + 1'b1 == CW'(DEPTH))) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (shift) begin
          cmd = CELL_SHIFT;
          if (cnt == CW'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (load_xfer) begin
        cnt <= cnt + 1'b1;
      end else if (shift) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          l_gt, l_vld, r_vld;
    logic [KW-1:0] l_key, r_key;

    if (i == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_vld = 1'b0;
      assign l_key = '0;
    end else begin : g_body
      assign l_gt  = cgt[i-1];
      assign l_vld = cvld[i-1];
      assign l_key = ckey[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_key = '0;
    end else begin : g_mid
      assign r_vld = cvld[i+1];
      assign r_key = ckey[i+1];
    end

    ks_cell #(.KW(KW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_key   (new_key),
      .left_gt   (l_gt),
      .left_vld  (l_vld),
      .left_key  (l_key),
      .right_vld (r_vld),
      .right_key (r_key),
      .gt        (cgt[i]),
      .vld       (cvld[i]),
      .key       (ckey[i])
    );
  end

  // Output register: takes the head of the chain on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (shift) begin
      ovalid <= 1'b1;
    end else if (sorted.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      okey   <= KEY_W'(ckey[0]);
      ofinal <= (cnt == CW'(1));
    end
  end

  assign sorted.valid      = ovalid;
  assign sorted.sorted_key = okey;
  assign sorted.final_res  = ofinal;

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cvld) == int'(cnt))
    else $error("key count out of step with occupied cells");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (cnt != '0) && cvld[0])
    else $error("draining with an empty chain");

  a_chain_empty_after_final: assert property (@(posedge clk) disable iff (rst)
    (shift && cnt == CW'(1)) |=> (cvld == '0) && sorted.final_res)
    else $error("chain not empty after final key left");

  a_no_load_while_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> !$past(load_xfer))
    else $error("key taken while draining");
`endif

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the key sorter end to end with random valid/ready traffic.
// Sets of keys are streamed in with random gaps on both sides. A software
// insertion list predicts the sorted run for each set, and every output
// transfer is checked against it in order. Sets end on last or on a full store.
// ----------------------------------------------------------------------------
module testbench;
  import ks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned KEY_BITS    = 32;
  localparam int          NUM_RANDOM  = 330;
  localparam int          TAIL_CYCLES = 20;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                          ({KEY_W{1'b1}} >> (KEY_W - KEY_BITS));

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             last;
    bit               drain_first;  // wait for all results before sending
  } key_item_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             fin;
  } sorted_item_t;

  logic clk = 1'b0;
  logic rst;

  ks_in_if  keys ();
  ks_out_if sorted ();

  key_sorter #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .keys   (keys),
    .sorted (sorted)
  );

  key_item_t        key_feed[$];
  logic [KEY_W-1:0] set_keys[$];    // current set, kept in ascending order
  sorted_item_t     sorted_due[$];
  sorted_item_t     due_item;
  key_item_t        feed_item;

  int cycles    = 0;
  int errors    = 0;
  int n_keys    = 0;
  int n_sets    = 0;
  int n_full    = 0;
  int n_results = 0;

  logic steady;
  assign steady = (cycles >= 300) && (cycles < 700);

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, sorted_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Expected run for the set: insert each key in place, flush on end of set.
  function automatic void load_key(input logic [KEY_W-1:0] k, input logic l);
    int               pos;
    logic [KEY_W-1:0] kk;
    sorted_item_t     r;
    kk  = k & KEY_MASK;
    pos = 0;
    while (pos < set_keys.size() && set_keys[pos] <= kk) pos++;
    set_keys.insert(pos, kk);
    n_keys++;
    if (l || set_keys.size() >= DEPTH) begin
      if (!l) n_full++;
      n_sets++;
      foreach (set_keys[i]) begin
        r.key = set_keys[i];
        r.fin = (i == set_keys.size() - 1);
        sorted_due.push_back(r);
      end
      set_keys.delete();
    end
  endfunction

  function automatic void push_item(input logic [KEY_W-1:0] k, input logic l,
                                    input bit hold);
    key_item_t it;
    it.key         = k;
    it.last        = l;
    it.drain_first = hold;
    key_feed.push_back(it);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 7);  // heavy duplicates
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_W-1){1'b0}}};
          3: return {1'b0, {(KEY_W-1){1'b1}}};
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic void add_set(input int n, input bit mark_last, input bit hold,
                                  input int mode);
    for (int i = 0; i < n; i++)
      push_item(rand_key(mode), mark_last && (i == n - 1), hold && (i == 0));
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      keys.valid <= 1'b0;
    end else if (!keys.valid || keys.ready) begin
      // a held item waits until keys.valid is low so the last transfer is predicted first
      if (key_feed.size() != 0 &&
          !(key_feed[0].drain_first && (keys.valid || sorted_due.size() != 0)) &&
          (steady || $urandom_range(0, 99) >= 29)) begin
        feed_item = key_feed.pop_front();
        keys.valid <= 1'b1;
        keys.key   <= feed_item.key;
        keys.last  <= feed_item.last;
      end else begin
        keys.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sorted.ready <= 1'b0;
    end else begin
      sorted.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (sorted.valid && sorted.ready) begin
        n_results++;
        if (sorted_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual key=%h final=%b",
                   $time, sorted.sorted_key, sorted.final_res);
        end else begin
          due_item = sorted_due.pop_front();
          if (due_item.key !== sorted.sorted_key || due_item.fin !== sorted.final_res) begin
            errors++;
            $display("%0t: mismatch, expected key=%h final=%b, actual key=%h final=%b",
                     $time, due_item.key, due_item.fin, sorted.sorted_key,
                     sorted.final_res);
          end
        end
      end
      if (keys.valid && keys.ready) load_key(keys.key, keys.last);
    end
  end

  initial begin : stim
    int n_queued;
    int r;
    int n;
    bit lst;
    bit first;
    rst          = 1'b1;
    keys.valid   = 1'b0;
    keys.key     = '0;
    keys.last    = 1'b0;
    sorted.ready = 1'b0;

    // single-key sets at both ends of the range
    push_item('0, 1'b1, 1'b0);
    push_item('1, 1'b1, 1'b0);
    // all equal
    push_item(32'h7, 1'b0, 1'b0);
    push_item(32'h7, 1'b0, 1'b0);
    push_item(32'h7, 1'b1, 1'b0);
    // extremes mixed, with a duplicate zero
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b0, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_item(32'h0000_0001, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b1, 1'b0);
    // already ascending, then strictly descending
    push_item(32'h1, 1'b0, 1'b0);
    push_item(32'h2, 1'b0, 1'b0);
    push_item(32'h3, 1'b1, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b0, 1'b1);
    push_item(32'h5555_5555, 1'b0, 1'b0);
    push_item(32'h0000_0003, 1'b0, 1'b0);
    push_item(32'h0000_0002, 1'b1, 1'b0);

    // random sets; the first fills the store without last
    n_queued = 0;
    first    = 1'b1;
    while (n_queued < NUM_RANDOM) begin
      r = $urandom_range(0, 99);
      if (first || r < 8) begin
        n   = DEPTH;
        lst = 1'b0;
      end else if (r < 12) begin
        n   = DEPTH;
        lst = 1'b1;
      end else begin
        n   = $urandom_range(1, 12);
        lst = 1'b1;
      end
      add_set(n, lst, first || ($urandom_range(0, 14) == 0), $urandom_range(0, 2));
      first    = 1'b0;
      n_queued += n;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (key_feed.size() != 0 || keys.valid) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sorted %0d sets (%0d ended by a full store) from %0d keys;",
             n_sets, n_full, n_keys);
    $display("%0d sorted results checked in %0d cycles with random stalls.",
             n_results, cycles);
    if (errors == 0 && sorted_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ks_pkg.sv
sv/ks_if.sv
sv/ks_cell.sv
sv/key_sorter.sv
dv/testbench.sv
